>>> rtl/core/pbcr_pkg.sv
// Shared types and constants for the planar bitplane color remap block.
// No dependencies; the rtl/core files other than pbcr_ram refer to it by scoped names.
`default_nettype none

package pbcr_pkg;

  localparam int PLANE_FIELDS    = 8;
  localparam int PIXELS_PER_WORD = 16;
  localparam int WORD_W          = 16;
  localparam int COLOR_W         = 8;
  localparam int DEPTH_W         = 4;
  localparam int QUEUE_DEPTH     = 2;
  // each map copy serves two pixels through its two read ports
  localparam int MAP_COPIES      = PIXELS_PER_WORD / 2;

  typedef enum logic {
    OP_SWAP  = 1'b0,
    OP_REMAP = 1'b1
  } op_t;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    op_t                        op;
    logic [COLOR_W-1:0]         first_color;
    logic [COLOR_W-1:0]         second_color;
    logic [DEPTH_W-1:0]         depth;
    word_t [PLANE_FIELDS-1:0]   words;
  } item_t;

  typedef enum logic [1:0] {
    STAGE_EMPTY,
    STAGE_REMAP,
    STAGE_SWAP_A,
    STAGE_SWAP_B
  } stage_state_t;

endpackage

`default_nettype wire

>>> rtl/core/pbcr_ram.sv
// Generic RAM: one write port, two read ports, registered read data with enable.
// Standalone; used for every copy of the color map.
`default_nettype none

module pbcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]        wr_addr,
  input  wire logic [WIDTH-1:0]                wr_data,
  input  wire logic                            rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]        rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0]        rd_addr_b,
  output logic      [WIDTH-1:0]                rd_data_a,
  output logic      [WIDTH-1:0]                rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pbcr_front.sv
// Front end: holds the truncate register, accepts items and classifies them.
// Depends on pbcr_pkg; feeds pbcr_queue with items that carry the effective depth.
`default_nettype none

module pbcr_front #(
  parameter int MAX_PLANES = 8
) (
  input  wire logic                                              clk,
  input  wire logic                                              rst,
  input  wire logic                                              cfg_valid,
  output logic                                                   cfg_ready,
  input  wire logic [pbcr_pkg::DEPTH_W-1:0]                      cfg_data,
  input  wire logic                                              item_valid,
  output logic                                                   item_stall,
  input  wire logic                                              operation,
  input  wire logic [pbcr_pkg::COLOR_W-1:0]                      first_color,
  input  wire logic [pbcr_pkg::COLOR_W-1:0]                      second_color,
  input  wire logic [pbcr_pkg::DEPTH_W-1:0]                      image_depth,
  input  wire pbcr_pkg::word_t [pbcr_pkg::PLANE_FIELDS-1:0]      plane_words,
  input  wire logic                                              queue_full,
  output logic                                                   push_valid,
  output pbcr_pkg::item_t                                        push_item
);

  localparam int DEPTH_W = pbcr_pkg::DEPTH_W;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH = DEPTH_W'(MAX_PLANES);

  logic [DEPTH_W-1:0] truncate_depth;
  logic [DEPTH_W-1:0] eff_depth;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      truncate_depth <= '0;
    end else if (cfg_valid && cfg_ready) begin
      truncate_depth <= cfg_data;
    end
  end

  // clamp to the register, then to the plane count the map holds
  always_comb begin
    eff_depth = image_depth;
    if (truncate_depth != '0 && eff_depth > truncate_depth) begin
      eff_depth = truncate_depth;
    end
    if (eff_depth > MAX_DEPTH) begin
      eff_depth = MAX_DEPTH;
    end
  end

  assign item_stall = queue_full;
  assign push_valid = item_valid && !queue_full;

  always_comb begin
    push_item              = '0;
    push_item.op           = pbcr_pkg::op_t'(operation);
    push_item.first_color  = first_color;
    push_item.second_color = second_color;
    push_item.depth        = eff_depth;
    push_item.words        = plane_words;
  end

endmodule

`default_nettype wire

>>> rtl/core/pbcr_queue.sv
// Short FIFO of classified items between the front end and the execution back end.
// Depends on pbcr_pkg for the item type and queue depth.
`default_nettype none

module pbcr_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  input  wire pbcr_pkg::item_t  push_item,
  output logic                  full,
  output logic                  pop_valid,
  output pbcr_pkg::item_t       pop_item,
  input  wire logic             pop
);

  localparam int DEPTH = pbcr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pbcr_pkg::item_t    slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item  = slots[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pbcr_back.sv
// Back end: color map copies, lookup stage, scatter of mapped bits and result register.
// Depends on pbcr_pkg and pbcr_ram; takes items from pbcr_queue.
`default_nettype none

module pbcr_back #(
  parameter int MAP_ENTRIES = 256,
  parameter int MAX_PLANES  = 8
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          q_valid,
  input  wire pbcr_pkg::item_t                               q_item,
  output logic                                               q_pop,
  output logic                                               result_valid,
  input  wire logic                                          result_stall,
  output pbcr_pkg::word_t [pbcr_pkg::PLANE_FIELDS-1:0]       result_words
);

  localparam int ENTRY_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int PL_W    = MAX_PLANES;
  localparam int PORTS   = pbcr_pkg::PIXELS_PER_WORD;
  localparam int PLANES  = pbcr_pkg::PLANE_FIELDS;
  localparam int COLOR_W = pbcr_pkg::COLOR_W;
  localparam int DEPTH_W = pbcr_pkg::DEPTH_W;

  pbcr_pkg::stage_state_t state, state_next;

  // lookup addresses for the cycle in which an item issues
  logic [PORTS-1:0][COLOR_W-1:0]  look_idx;
  logic [PORTS-1:0][ENTRY_W-1:0]  rd_addr;
  logic [PORTS-1:0][PL_W-1:0]     rd_ident;
  logic [PORTS-1:0]               rd_range;
  logic [PORTS-1:0]               rd_hit;
  logic [PORTS-1:0][PL_W-1:0]     rd_data;
  logic [MAP_ENTRIES-1:0]         written;

  // lookup stage registers
  logic [PORTS-1:0][PL_W-1:0]     d_ident;
  logic [PORTS-1:0]               d_hit;
  logic [DEPTH_W-1:0]             d_depth;
  pbcr_pkg::word_t [PLANES-1:0]   d_words;
  logic [ENTRY_W-1:0]             d_addr_a;
  logic [ENTRY_W-1:0]             d_addr_b;
  logic                           d_swap_ok;

  logic [PORTS-1:0][PL_W-1:0]     mapped;
  logic [PORTS-1:0][COLOR_W-1:0]  mapped_ext;
  pbcr_pkg::word_t [PLANES-1:0]   scatter;

  logic                           out_adv;
  logic                           stage_free;
  logic                           issue;
  logic                           load_out;
  logic                           wr_en;
  logic [ENTRY_W-1:0]             wr_addr;
  logic [PL_W-1:0]                wr_data;

  // one color index per pixel from planes below the depth; swap colors go to ports 0 and 1
  always_comb begin
    for (int p = 0; p < PORTS; p++) begin
      look_idx[p] = '0;
      for (int k = 0; k < PLANES; k++) begin
        if (k < int'(q_item.depth)) begin
          look_idx[p][k] = q_item.words[k][p];
        end
      end
    end
    if (q_item.op == pbcr_pkg::OP_SWAP) begin
      look_idx[0] = q_item.first_color;
      look_idx[1] = q_item.second_color;
    end
    for (int p = 0; p < PORTS; p++) begin
      rd_addr[p]  = look_idx[p][ENTRY_W-1:0];
      rd_ident[p] = look_idx[p][PL_W-1:0];
      rd_range[p] = int'(look_idx[p]) < MAP_ENTRIES;
      // an entry never written still reads as its own index
      rd_hit[p]   = rd_range[p] && written[rd_addr[p]];
    end
  end

  for (genvar c = 0; c < pbcr_pkg::MAP_COPIES; c++) begin : g_map
    pbcr_ram #(
      .WIDTH (PL_W),
      .DEPTH (MAP_ENTRIES)
    ) u_map (
      .clk       (clk),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (issue),
      .rd_addr_a (rd_addr[2*c]),
      .rd_addr_b (rd_addr[2*c+1]),
      .rd_data_a (rd_data[2*c]),
      .rd_data_b (rd_data[2*c+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      d_ident   <= rd_ident;
      d_hit     <= rd_hit;
      d_depth   <= q_item.depth;
      d_words   <= q_item.words;
      d_addr_a  <= rd_addr[0];
      d_addr_b  <= rd_addr[1];
      d_swap_ok <= rd_range[0] && rd_range[1];
    end
  end

  // write mapped bits back into the planes below the depth
  always_comb begin
    for (int p = 0; p < PORTS; p++) begin
      mapped[p]               = d_hit[p] ? rd_data[p] : d_ident[p];
      mapped_ext[p]           = '0;
      mapped_ext[p][PL_W-1:0] = mapped[p];
    end
    for (int k = 0; k < PLANES; k++) begin
      for (int p = 0; p < PORTS; p++) begin
        scatter[k][p] = (k < int'(d_depth)) ? mapped_ext[p][k] : d_words[k][p];
      end
    end
  end

  assign out_adv = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbcr_pkg::STAGE_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  // stage outputs; a swap writes its first entry, then its second
  always_comb begin
    stage_free = 1'b0;
    load_out   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = d_addr_a;
    wr_data    = mapped[1];
    unique case (state)
      pbcr_pkg::STAGE_EMPTY: begin
        stage_free = 1'b1;
      end
      pbcr_pkg::STAGE_REMAP: begin
        load_out   = out_adv;
        stage_free = out_adv;
      end
      pbcr_pkg::STAGE_SWAP_A: begin
        wr_en = d_swap_ok;
      end
      pbcr_pkg::STAGE_SWAP_B: begin
        wr_en   = d_swap_ok;
        wr_addr = d_addr_b;
        wr_data = mapped[0];
      end
    endcase
  end

  assign issue = q_valid && stage_free;
  assign q_pop = issue;

  always_comb begin
    state_next = state;
    unique case (state)
      pbcr_pkg::STAGE_EMPTY, pbcr_pkg::STAGE_REMAP: begin
        if (stage_free) begin
          if (!issue) begin
            state_next = pbcr_pkg::STAGE_EMPTY;
          end else if (q_item.op == pbcr_pkg::OP_REMAP) begin
            state_next = pbcr_pkg::STAGE_REMAP;
          end else begin
            state_next = pbcr_pkg::STAGE_SWAP_A;
          end
        end
      end
      pbcr_pkg::STAGE_SWAP_A: begin
        state_next = pbcr_pkg::STAGE_SWAP_B;
      end
      pbcr_pkg::STAGE_SWAP_B: begin
        state_next = pbcr_pkg::STAGE_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_words <= scatter;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/planar_bitplane_color_remap.sv
// Planar bitplane color remap: remaps 16 pixels of up to 8 bitplanes through a color map.
// Input channel item_valid/item_stall carries swap and remap items; a swap exchanges two
// map entries and gives no result, a remap gives one result on result_valid/result_stall.
// An item is transferred at a clock edge with valid high and stall low on its channel.
// truncate_depth is written through cfg_valid/cfg_ready (always ready); the user must
// write it only while idle, which the block itself does not enforce. A remap is queued,
// issues its lookups once the back end is free and is loaded into the result register.
// Throughput: one remap per cycle while result_stall is low, since each of the eight
// map copies serves two pixels through its two read ports. A swap holds the back end
// for a read of both entries, then one write per entry via each copy's single write port.
// A two-entry queue between front and back end absorbs short stalls on either side;
// while the receiver stalls, the result register holds and the queue fills, then
// item_stall rises.
// Reset: the map reads as identity at once (per-entry written bits are cleared, no
// clearing pass), truncate_depth returns to zero, queue and result register empty.
// Depends on pbcr_pkg, pbcr_front, pbcr_queue, pbcr_back and pbcr_ram.
`default_nettype none

module planar_bitplane_color_remap #(
  parameter int MAP_ENTRIES = 256,
  parameter int MAX_PLANES  = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pbcr_pkg::DEPTH_W-1:0]      truncate_depth,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire logic                              operation,
  input  wire logic [pbcr_pkg::COLOR_W-1:0]      first_color,
  input  wire logic [pbcr_pkg::COLOR_W-1:0]      second_color,
  input  wire logic [pbcr_pkg::DEPTH_W-1:0]      image_depth,
  input  wire logic [pbcr_pkg::WORD_W-1:0]       plane_word_0,
  input  wire logic [pbcr_pkg::WORD_W-1:0]       plane_word_1,
  input  wire logic [pbcr_pkg::WORD_W-1:0]       plane_word_2,
  input  wire logic [pbcr_pkg::WORD_W-1:0]       plane_word_3,
  input  wire logic [pbcr_pkg::WORD_W-1:0]       plane_word_4,
  input  wire logic [pbcr_pkg::WORD_W-1:0]       plane_word_5,
  input  wire logic [pbcr_pkg::WORD_W-1:0]       plane_word_6,
  input  wire logic [pbcr_pkg::WORD_W-1:0]       plane_word_7,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output logic      [pbcr_pkg::WORD_W-1:0]       result_plane_0,
  output logic      [pbcr_pkg::WORD_W-1:0]       result_plane_1,
  output logic      [pbcr_pkg::WORD_W-1:0]       result_plane_2,
  output logic      [pbcr_pkg::WORD_W-1:0]       result_plane_3,
  output logic      [pbcr_pkg::WORD_W-1:0]       result_plane_4,
  output logic      [pbcr_pkg::WORD_W-1:0]       result_plane_5,
  output logic      [pbcr_pkg::WORD_W-1:0]       result_plane_6,
  output logic      [pbcr_pkg::WORD_W-1:0]       result_plane_7
);

  pbcr_pkg::word_t [pbcr_pkg::PLANE_FIELDS-1:0] plane_words;
  pbcr_pkg::word_t [pbcr_pkg::PLANE_FIELDS-1:0] result_words;

  logic             queue_full;
  logic             push_valid;
  pbcr_pkg::item_t  push_item;
  logic             q_valid;
  pbcr_pkg::item_t  q_item;
  logic             q_pop;

  assign plane_words = {plane_word_7, plane_word_6, plane_word_5, plane_word_4,
                        plane_word_3, plane_word_2, plane_word_1, plane_word_0};

  assign result_plane_0 = result_words[0];
  assign result_plane_1 = result_words[1];
  assign result_plane_2 = result_words[2];
  assign result_plane_3 = result_words[3];
  assign result_plane_4 = result_words[4];
  assign result_plane_5 = result_words[5];
  assign result_plane_6 = result_words[6];
  assign result_plane_7 = result_words[7];

  pbcr_front #(
    .MAX_PLANES (MAX_PLANES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (truncate_depth),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .first_color  (first_color),
    .second_color (second_color),
    .image_depth  (image_depth),
    .plane_words  (plane_words),
    .queue_full   (queue_full),
    .push_valid   (push_valid),
    .push_item    (push_item)
  );

  pbcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (queue_full),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  pbcr_back #(
    .MAP_ENTRIES (MAP_ENTRIES),
    .MAX_PLANES  (MAX_PLANES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_words (result_words)
  );

  // reset empties the queue and the result register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("reset left a result or a stall behind");

  // an empty queue never back-pressures the sender
  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> !item_stall)
    else $error("input stalled with an empty queue");

  // a queued item stays until the back end takes it
  a_queue_holds: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_pop |=> q_valid)
    else $error("queued item lost without a pop");

endmodule

`default_nettype wire
